@@ sv/tcl_pkg.sv @@
package tcl_pkg;

  localparam int unsigned PositionBitsDefault = 16;
  localparam int unsigned OutPosBits = 16;
  localparam int unsigned MaxItems = 6;
  localparam int unsigned QueueDepth = 4;

  // lexer modes
  typedef enum logic [2:0] {
    MODE_PLAIN      = 3'd0,
    MODE_CODE       = 3'd1,
    MODE_LINE       = 3'd2,
    MODE_BLOCK      = 3'd3,
    MODE_STRING     = 3'd4,
    MODE_SKIP_CODE  = 3'd5,
    MODE_SKIP_PLAIN = 3'd6,
    MODE_SKIP_BLOCK = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_VALUE = 2'd1,
    KIND_END   = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CLASS_PLAIN  = 3'd0,
    CLASS_IDENT  = 3'd1,
    CLASS_OPER   = 3'd2,
    CLASS_STRING = 3'd3,
    CLASS_NUMBER = 3'd4
  } class_e;

  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChQuest = 8'h3f;
  localparam logic [7:0] ChGt    = 8'h3e;
  localparam logic [7:0] ChSlash = 8'h2f;
  localparam logic [7:0] ChStar  = 8'h2a;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBack  = 8'h5c;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChNl    = 8'h0a;

  // one result item
  typedef struct packed {
    logic [1:0]            kind;
    logic [2:0]            cls;
    logic [7:0]            ch;
    logic [OutPosBits-1:0] row;
    logic [OutPosBits-1:0] col;
  } item_t;

  // one step's worth of results, handed from front to back
  typedef struct packed {
    logic [2:0]               count;
    item_t [MaxItems-1:0]     items;
  } batch_t;

  function automatic logic is_punct(logic [7:0] c);
    return c == 8'h28 || c == 8'h29 || c == 8'h5b || c == 8'h5d || c == 8'h7b ||
           c == 8'h7d || c == 8'h2c || c == 8'h3b;
  endfunction

  function automatic logic is_op(logic [7:0] c);
    return c == ChLt || c == ChGt || c == 8'h3d || c == 8'h3a || c == 8'h2b ||
           c == 8'h2d || c == ChStar || c == ChSlash || c == 8'h7c || c == 8'h26 ||
           c == 8'h21;
  endfunction

  function automatic logic ends_word(logic [7:0] c);
    return is_punct(c) || is_op(c) || c == 8'h20 || c == ChPct || c == ChQuest ||
           c == 8'h00 || c == 8'h09 || c == 8'h0d || c == ChNl || c == ChBack;
  endfunction

endpackage

@@ sv/tcl_front.sv @@
module tcl_front #(
  parameter int unsigned PositionBits = tcl_pkg::PositionBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  logic [7:0]      source_byte_i,
  input  logic            end_of_source_i,
  output logic            push_o,
  output tcl_pkg::batch_t batch_o,
  input  logic            space_i
);

  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

  tcl_pkg::mode_e            mode_q, mode_d;
  logic [7:0]                held_q, held_d;
  logic                      hvalid_q, hvalid_d;
  logic                      esc_q, esc_d;
  logic                      open_q, open_d;
  logic [2:0]                cls_q, cls_d;
  logic [PositionBits-1:0]   row_q, row_d, col_q, col_d, trow_q, trow_d, tcol_q, tcol_d;
  tcl_pkg::batch_t           b;
  logic                      acc;

  // position as carried on the output, extended or cut to its width
  function automatic logic [tcl_pkg::OutPosBits-1:0] pos_out(
    input logic [PositionBits-1:0] p
  );
    return tcl_pkg::OutPosBits'(p);
  endfunction

  assign ready_o = space_i;
  assign acc     = valid_i && space_i;

  // combinational step of the lexer
  always_comb begin
    logic [7:0] c;
    logic [7:0] n;
    logic       has_n;
    logic       fresh;
    logic [7:0] r;
    logic       r_ok;
    c = held_q;
    n = source_byte_i;
    has_n = !end_of_source_i;
    fresh = 1'b0;
    r = 8'h00;
    r_ok = 1'b1;
    mode_d = mode_q; held_d = held_q; hvalid_d = hvalid_q; esc_d = esc_q;
    open_d = open_q; cls_d = cls_q; row_d = row_q; col_d = col_q;
    trow_d = trow_q; tcol_d = tcol_q;
    b = '0;

    if (hvalid_q) begin
      unique case (mode_q)
        tcl_pkg::MODE_PLAIN: begin
          if (c == tcl_pkg::ChLt && has_n && n == tcl_pkg::ChQuest) begin
            if (open_d) begin
              b.items[b.count] = '{tcl_pkg::KIND_END, cls_d, 8'h00,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
            end
            open_d = 1'b0;
            mode_d = tcl_pkg::MODE_SKIP_CODE;
          end else begin
            if (!open_d) begin
              open_d = 1'b1; cls_d = tcl_pkg::CLASS_PLAIN; trow_d = row_q; tcol_d = col_q;
              b.items[b.count] = '{tcl_pkg::KIND_START, cls_d, 8'h00,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
            end
            b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, c,
                                 pos_out(trow_d), pos_out(tcol_d)};
            b.count = b.count + 3'd1;
          end
        end
        tcl_pkg::MODE_CODE: begin
          fresh = 1'b1;
          if (open_d) begin
            if (cls_d == tcl_pkg::CLASS_OPER ? tcl_pkg::is_op(c)
                                             : !tcl_pkg::ends_word(c)) begin
              b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, c,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
              fresh = 1'b0;
            end else begin
              b.items[b.count] = '{tcl_pkg::KIND_END, cls_d, 8'h00,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
              open_d = 1'b0;
            end
          end
        end
        tcl_pkg::MODE_LINE: begin
          if (c == tcl_pkg::ChQuest && has_n && n == tcl_pkg::ChGt)
            mode_d = tcl_pkg::MODE_SKIP_PLAIN;
          else if (c == tcl_pkg::ChNl) mode_d = tcl_pkg::MODE_CODE;
        end
        tcl_pkg::MODE_BLOCK: begin
          if (c == tcl_pkg::ChStar && has_n && n == tcl_pkg::ChSlash)
            mode_d = tcl_pkg::MODE_SKIP_CODE;
        end
        tcl_pkg::MODE_STRING: begin
          if (esc_q) begin
            esc_d = 1'b0;
            unique case (c)
              tcl_pkg::ChQuote: r = tcl_pkg::ChQuote;
              tcl_pkg::ChBack:  r = tcl_pkg::ChBack;
              8'h62: r = 8'd8;
              8'h66: r = 8'd12;
              8'h6e: r = 8'd10;
              8'h72: r = 8'd13;
              8'h74: r = 8'd9;
              8'h76: r = 8'd11;
              default: r_ok = 1'b0;
            endcase
            if (!r_ok) begin
              b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, tcl_pkg::ChBack,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
              r = c;
            end
            b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, r,
                                 pos_out(trow_d), pos_out(tcol_d)};
            b.count = b.count + 3'd1;
          end else if (c == tcl_pkg::ChQuote) begin
            if (open_d) begin
              b.items[b.count] = '{tcl_pkg::KIND_END, cls_d, 8'h00,
                                   pos_out(trow_d), pos_out(tcol_d)};
              b.count = b.count + 3'd1;
            end
            open_d = 1'b0;
            mode_d = tcl_pkg::MODE_CODE;
          end else if (c == tcl_pkg::ChBack) begin
            esc_d = 1'b1;
          end else begin
            b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, c,
                                 pos_out(trow_d), pos_out(tcol_d)};
            b.count = b.count + 3'd1;
          end
        end
        tcl_pkg::MODE_SKIP_CODE:  mode_d = tcl_pkg::MODE_CODE;
        tcl_pkg::MODE_SKIP_PLAIN: mode_d = tcl_pkg::MODE_PLAIN;
        tcl_pkg::MODE_SKIP_BLOCK: mode_d = tcl_pkg::MODE_BLOCK;
        default: mode_d = tcl_pkg::MODE_BLOCK;
      endcase

      // fresh character in code
      if (fresh && !(c == 8'h20 || (c >= 8'd9 && c <= 8'd13))) begin
        if (c == tcl_pkg::ChQuest && has_n && n == tcl_pkg::ChGt) begin
          mode_d = tcl_pkg::MODE_SKIP_PLAIN;
        end else if (c == tcl_pkg::ChSlash && has_n && n == tcl_pkg::ChSlash) begin
          mode_d = tcl_pkg::MODE_LINE;
        end else if (c == tcl_pkg::ChSlash && has_n && n == tcl_pkg::ChStar) begin
          mode_d = tcl_pkg::MODE_SKIP_BLOCK;
        end else if (c == tcl_pkg::ChQuote) begin
          open_d = 1'b1; cls_d = tcl_pkg::CLASS_STRING; trow_d = row_q; tcol_d = col_q;
          b.items[b.count] = '{tcl_pkg::KIND_START, cls_d, 8'h00,
                               pos_out(trow_d), pos_out(tcol_d)};
          b.count = b.count + 3'd1;
          mode_d = tcl_pkg::MODE_STRING;
        end else if (!(c == tcl_pkg::ChPct || c == tcl_pkg::ChQuest ||
                       c == tcl_pkg::ChBack || c == 8'h00)) begin
          open_d = 1'b1;
          trow_d = row_q; tcol_d = col_q;
          if (tcl_pkg::is_punct(c) || tcl_pkg::is_op(c)) cls_d = tcl_pkg::CLASS_OPER;
          else if (c >= 8'h30 && c <= 8'h39)         cls_d = tcl_pkg::CLASS_NUMBER;
          else                                       cls_d = tcl_pkg::CLASS_IDENT;
          b.items[b.count] = '{tcl_pkg::KIND_START, cls_d, 8'h00,
                               pos_out(trow_d), pos_out(tcol_d)};
          b.count = b.count + 3'd1;
          b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, c,
                               pos_out(trow_d), pos_out(tcol_d)};
          b.count = b.count + 3'd1;
          if (tcl_pkg::is_punct(c)) begin
            b.items[b.count] = '{tcl_pkg::KIND_END, cls_d, 8'h00,
                                 pos_out(trow_d), pos_out(tcol_d)};
            b.count = b.count + 3'd1;
            open_d = 1'b0;
          end
        end
      end

      // position update
      if (c == tcl_pkg::ChNl) begin
        if (row_q != PosMax) row_d = row_q + 1'b1;
        col_d = '0;
      end else if (col_q != PosMax) begin
        col_d = col_q + 1'b1;
      end
    end

    if (end_of_source_i) begin
      if (esc_d && open_d) begin
        b.items[b.count] = '{tcl_pkg::KIND_VALUE, cls_d, tcl_pkg::ChBack,
                             pos_out(trow_d), pos_out(tcol_d)};
        b.count = b.count + 3'd1;
      end
      if (open_d) begin
        b.items[b.count] = '{tcl_pkg::KIND_END, cls_d, 8'h00,
                             pos_out(trow_d), pos_out(tcol_d)};
        b.count = b.count + 3'd1;
      end
      mode_d = tcl_pkg::MODE_PLAIN; held_d = '0; hvalid_d = 1'b0; esc_d = 1'b0;
      open_d = 1'b0; cls_d = '0; row_d = '0; col_d = '0; trow_d = '0; tcol_d = '0;
    end else begin
      held_d = source_byte_i;
      hvalid_d = 1'b1;
    end
  end

  assign push_o  = acc && (b.count != 3'd0);
  assign batch_o = b;

  // lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= tcl_pkg::MODE_PLAIN; held_q <= '0; hvalid_q <= 1'b0; esc_q <= 1'b0;
      open_q <= 1'b0; cls_q <= '0; row_q <= '0; col_q <= '0; trow_q <= '0; tcol_q <= '0;
    end else if (acc) begin
      mode_q <= mode_d; held_q <= held_d; hvalid_q <= hvalid_d; esc_q <= esc_d;
      open_q <= open_d; cls_q <= cls_d; row_q <= row_d; col_q <= col_d;
      trow_q <= trow_d; tcol_q <= tcol_d;
    end
  end

endmodule

@@ sv/tcl_queue.sv @@
module tcl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tcl_pkg::batch_t batch_i,
  output logic            space_o,
  output logic            valid_o,
  output tcl_pkg::batch_t batch_o,
  input  logic            pop_i
);

  localparam int unsigned AddrBits = $clog2(tcl_pkg::QueueDepth);

  tcl_pkg::batch_t      mem_q [tcl_pkg::QueueDepth];
  logic [AddrBits-1:0]  wr_q, rd_q;
  logic [AddrBits:0]    cnt_q;

  assign space_o = cnt_q != AddrBits'(0) + (AddrBits+1)'(tcl_pkg::QueueDepth)
                   ? 1'b1 : 1'b0;
  assign valid_o = cnt_q != '0;
  assign batch_o = mem_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= batch_i;
  end

  // pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AddrBits+1)'(push_i) - (AddrBits+1)'(pop_i);
    end
  end

endmodule

@@ sv/tcl_back.sv @@
module tcl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  tcl_pkg::batch_t batch_i,
  output logic            pop_o,
  output logic            valid_o,
  input  logic            ready_i,
  output tcl_pkg::item_t  item_o,
  output logic            last_o
);

  logic [2:0] idx_q;
  logic       fire;

  assign valid_o = valid_i;
  assign item_o  = batch_i.items[idx_q];
  assign last_o  = (idx_q + 3'd1) == batch_i.count;
  assign fire    = valid_i && ready_i;
  assign pop_o   = fire && last_o;

  // walk through the items of one batch
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) idx_q <= '0;
    else if (fire) idx_q <= last_o ? 3'd0 : idx_q + 3'd1;
  end

endmodule

@@ sv/template_code_lexer_core.sv @@
// template code lexer
// input channel: valid_i/ready_o with source_byte_i and end_of_source_i;
// one byte is accepted per cycle while the result queue has room.
// output channel: valid_o/ready_i with item_kind_o, token_class_o,
// value_char_o, start_row_o, start_column_o and last_of_step_o.
// a byte is lexed when its lookahead byte arrives (or end of source), so
// results of one byte appear with the next accepted item. the front lexes a
// byte in the accept cycle and pushes up to six result items as one batch into
// a four-entry queue; the back streams one item per cycle from the queue head while ready_i is high.
// results of an accepted byte are registered in the queue before the back presents them.
// one byte per cycle while results fit; a byte giving k items occupies the
// output for k handshakes, so the output port sets sustained rate.
// reset clears lexer state, positions and queue; nothing is in flight.
// when the receiver stalls, the queue fills and ready_o falls; no item is lost.
module template_code_lexer_core #(
  parameter int unsigned PositionBits = tcl_pkg::PositionBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        end_of_source_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  item_kind_o,
  output logic [2:0]  token_class_o,
  output logic [7:0]  value_char_o,
  output logic [15:0] start_row_o,
  output logic [15:0] start_column_o,
  output logic        last_of_step_o
);

  logic            push, space, qvalid, pop;
  tcl_pkg::batch_t fbatch, qbatch;
  tcl_pkg::item_t  item;

  tcl_front #(.PositionBits(PositionBits)) u_front (
    .clk_i, .rst_ni, .valid_i, .ready_o, .source_byte_i, .end_of_source_i,
    .push_o(push), .batch_o(fbatch), .space_i(space)
  );

  tcl_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .batch_i(fbatch), .space_o(space),
    .valid_o(qvalid), .batch_o(qbatch), .pop_i(pop)
  );

  tcl_back u_back (
    .clk_i, .rst_ni, .valid_i(qvalid), .batch_i(qbatch), .pop_o(pop),
    .valid_o, .ready_i, .item_o(item), .last_o(last_of_step_o)
  );

  assign item_kind_o    = item.kind;
  assign token_class_o  = item.cls;
  assign value_char_o   = item.ch;
  assign start_row_o    = item.row;
  assign start_column_o = item.col;

  // checks
  a_pop_needs_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> qvalid) else $error("pop from empty queue");
  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> space) else $error("push into full queue");
  a_kind_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (item_kind_o != 2'd3)) else $error("bad item kind");

endmodule

@@ tb/sv/tb_template_code_lexer_core.sv @@
`timescale 1ns / 100ps

module tb_template_code_lexer_core;

  localparam int unsigned PosMax = 16'hffff;
  localparam int unsigned LimitCycles = 20000;
  localparam logic [8:0] NoLook = 9'h100;

  typedef struct {
    logic [1:0]  kind;
    logic [2:0]  cls;
    logic [7:0]  ch;
    logic [15:0] row;
    logic [15:0] col;
    logic        last;
  } lex_item_t;

  // one directed row; nexp = -1 means check against predictor only
  typedef struct {
    logic [7:0] b;
    logic       eos;
    int         nexp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        valid_i;
  logic        ready_o;
  logic [7:0]  source_byte_i;
  logic        end_of_source_i;
  logic        valid_o;
  logic        ready_i;
  logic [1:0]  item_kind_o;
  logic [2:0]  token_class_o;
  logic [7:0]  value_char_o;
  logic [15:0] start_row_o;
  logic [15:0] start_column_o;
  logic        last_of_step_o;

  template_code_lexer_core DUT (
    .clk_i,
    .rst_ni,
    .valid_i,
    .ready_o,
    .source_byte_i,
    .end_of_source_i,
    .valid_o,
    .ready_i,
    .item_kind_o,
    .token_class_o,
    .value_char_o,
    .start_row_o,
    .start_column_o,
    .last_of_step_o
  );

  // lexer state mirror
  tcl_pkg::mode_e lx_mode;
  logic [7:0]  lx_held;
  logic        lx_held_vld;
  logic        lx_esc;
  logic        lx_open;
  logic [2:0]  lx_cls;
  int unsigned lx_row, lx_col, lx_trow, lx_tcol;

  lex_item_t   pending_items[$];
  lex_item_t   step_items[$];
  int          mismatches;
  int unsigned cycle_count;
  int unsigned sent_count;
  bit          hold_off;
  bit          no_idle;
  bit          quiet_done;
  bit          hold_done;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  function automatic void lexer_clear();
    lx_mode = tcl_pkg::MODE_PLAIN;
    lx_held = 8'h00;
    lx_held_vld = 1'b0;
    lx_esc = 1'b0;
    lx_open = 1'b0;
    lx_cls = tcl_pkg::CLASS_PLAIN;
    lx_row = 0;
    lx_col = 0;
    lx_trow = 0;
    lx_tcol = 0;
  endfunction

  function automatic void push_item(input tcl_pkg::kind_e k, input logic [7:0] c);
    lex_item_t it;
    if (step_items.size() >= tcl_pkg::MaxItems) return;
    it.kind = k;
    it.cls = lx_cls;
    it.ch = c;
    it.row = lx_trow[15:0];
    it.col = lx_tcol[15:0];
    it.last = 1'b0;
    step_items.insert(step_items.size(), it);
  endfunction

  function automatic void token_begin(input tcl_pkg::class_e c);
    lx_open = 1'b1;
    lx_cls = c;
    lx_trow = lx_row;
    lx_tcol = lx_col;
    push_item(tcl_pkg::KIND_START, 8'h00);
  endfunction

  function automatic void token_finish();
    if (lx_open) push_item(tcl_pkg::KIND_END, 8'h00);
    lx_open = 1'b0;
  endfunction

  function automatic logic punct_c(input logic [7:0] c);
    return c inside {8'h28, 8'h29, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h2c, 8'h3b};
  endfunction

  function automatic logic oper_c(input logic [7:0] c);
    return c inside {8'h3c, 8'h3e, 8'h3d, 8'h3a, 8'h2b, 8'h2d, 8'h2a, 8'h2f,
                     8'h7c, 8'h26, 8'h21};
  endfunction

  function automatic logic word_stop(input logic [7:0] c);
    return punct_c(c) || oper_c(c) ||
           c inside {8'h20, 8'h25, 8'h3f, 8'h00, 8'h09, 8'h0d, 8'h0a, 8'h5c};
  endfunction

  // fresh character in code mode, n is the lookahead (NoLook if none)
  function automatic void code_start(input logic [7:0] c, input logic [8:0] n);
    if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) return;
    if (c == tcl_pkg::ChQuest && n == {1'b0, tcl_pkg::ChGt})
      lx_mode = tcl_pkg::MODE_SKIP_PLAIN;
    else if (c == tcl_pkg::ChSlash && n == {1'b0, tcl_pkg::ChSlash})
      lx_mode = tcl_pkg::MODE_LINE;
    else if (c == tcl_pkg::ChSlash && n == {1'b0, tcl_pkg::ChStar})
      lx_mode = tcl_pkg::MODE_SKIP_BLOCK;
    else if (c == tcl_pkg::ChQuote) begin
      token_begin(tcl_pkg::CLASS_STRING);
      lx_mode = tcl_pkg::MODE_STRING;
    end else if (punct_c(c)) begin
      token_begin(tcl_pkg::CLASS_OPER);
      push_item(tcl_pkg::KIND_VALUE, c);
      token_finish();
    end else if (oper_c(c)) begin
      token_begin(tcl_pkg::CLASS_OPER);
      push_item(tcl_pkg::KIND_VALUE, c);
    end else if (c == tcl_pkg::ChPct || c == tcl_pkg::ChQuest ||
                 c == tcl_pkg::ChBack || c == 8'h00) begin
      // stray character dropped
    end else begin
      token_begin((c >= "0" && c <= "9") ? tcl_pkg::CLASS_NUMBER : tcl_pkg::CLASS_IDENT);
      push_item(tcl_pkg::KIND_VALUE, c);
    end
  endfunction

  function automatic logic [8:0] escape_value(input logic [7:0] c);
    case (c)
      tcl_pkg::ChQuote: return {1'b0, tcl_pkg::ChQuote};
      tcl_pkg::ChBack:  return {1'b0, tcl_pkg::ChBack};
      "b":     return 9'd8;
      "f":     return 9'd12;
      "n":     return 9'd10;
      "r":     return 9'd13;
      "t":     return 9'd9;
      "v":     return 9'd11;
      default: return NoLook;
    endcase
  endfunction

  function automatic void lex_char(input logic [7:0] c, input logic [8:0] n);
    logic [8:0] r;
    case (lx_mode)
      tcl_pkg::MODE_PLAIN: begin
        if (c == tcl_pkg::ChLt && n == {1'b0, tcl_pkg::ChQuest}) begin
          token_finish();
          lx_mode = tcl_pkg::MODE_SKIP_CODE;
        end else begin
          if (!lx_open) token_begin(tcl_pkg::CLASS_PLAIN);
          push_item(tcl_pkg::KIND_VALUE, c);
        end
      end
      tcl_pkg::MODE_CODE: begin
        if (lx_open && ((lx_cls == tcl_pkg::CLASS_OPER) ? oper_c(c) : !word_stop(c)))
          push_item(tcl_pkg::KIND_VALUE, c);
        else begin
          token_finish();
          code_start(c, n);
        end
      end
      tcl_pkg::MODE_LINE: begin
        if (c == tcl_pkg::ChQuest && n == {1'b0, tcl_pkg::ChGt})
          lx_mode = tcl_pkg::MODE_SKIP_PLAIN;
        else if (c == tcl_pkg::ChNl) lx_mode = tcl_pkg::MODE_CODE;
      end
      tcl_pkg::MODE_BLOCK: begin
        if (c == tcl_pkg::ChStar && n == {1'b0, tcl_pkg::ChSlash})
          lx_mode = tcl_pkg::MODE_SKIP_CODE;
      end
      tcl_pkg::MODE_STRING: begin
        if (lx_esc) begin
          lx_esc = 1'b0;
          r = escape_value(c);
          if (r == NoLook) begin
            push_item(tcl_pkg::KIND_VALUE, tcl_pkg::ChBack);
            push_item(tcl_pkg::KIND_VALUE, c);
          end else push_item(tcl_pkg::KIND_VALUE, r[7:0]);
        end else if (c == tcl_pkg::ChQuote) begin
          token_finish();
          lx_mode = tcl_pkg::MODE_CODE;
        end else if (c == tcl_pkg::ChBack) lx_esc = 1'b1;
        else push_item(tcl_pkg::KIND_VALUE, c);
      end
      tcl_pkg::MODE_SKIP_CODE:  lx_mode = tcl_pkg::MODE_CODE;
      tcl_pkg::MODE_SKIP_PLAIN: lx_mode = tcl_pkg::MODE_PLAIN;
      default:                  lx_mode = tcl_pkg::MODE_BLOCK;
    endcase
    if (c == tcl_pkg::ChNl) begin
      if (lx_row < PosMax) lx_row++;
      lx_col = 0;
    end else if (lx_col < PosMax) lx_col++;
  endfunction

  // works out the items one accepted byte causes and queues them
  function automatic int lex_predict(input logic [7:0] b, input logic eos);
    step_items.delete();
    if (eos) begin
      if (lx_held_vld) lex_char(lx_held, NoLook);
      if (lx_esc && lx_open) push_item(tcl_pkg::KIND_VALUE, tcl_pkg::ChBack);
      token_finish();
      lexer_clear();
    end else begin
      if (lx_held_vld) lex_char(lx_held, {1'b0, b});
      lx_held = b;
      lx_held_vld = 1'b1;
    end
    if (step_items.size() > 0) step_items[step_items.size()-1].last = 1'b1;
    foreach (step_items[i]) pending_items.insert(pending_items.size(), step_items[i]);
    return step_items.size();
  endfunction

  // drive one byte and wait for its acceptance
  task automatic send_byte(input logic [7:0] b, input logic eos, input int nexp);
    int got;
    while (!no_idle && $urandom_range(99) < 15) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i <= 1'b1;
    source_byte_i <= b;
    end_of_source_i <= eos;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    sent_count++;
    got = lex_predict(b, eos);
    if (nexp >= 0 && got != nexp)
      report_mismatch($sformatf("byte %02h eos %0b: %0d items, table says %0d",
                                b, eos, got, nexp));
  endtask

  // random code fragment, mostly well formed
  task automatic send_fragment();
    int sel;
    int len;
    string s;
    sel = $urandom_range(9);
    case (sel)
      0: s = "<?";
      1: s = "?>";
      2: s = "foo_1 ";
      3: s = "\"a\\n\\q\\\\\" ";
      4: s = "<=>+ ";
      5: s = "/* x */";
      6: s = "// c\n";
      7: s = "(x,9);";
      8: s = "\n";
      default: s = "";
    endcase
    if (sel == 9) begin
      len = $urandom_range(3, 1);
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(255)), 1'b0, -1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, -1);
    end
  endtask

  // receiver: random stalls, one long hold-off
  initial begin
    int hold;
    ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        ready_i <= 1'b0;
        for (hold = 0; hold < 60; hold++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      ready_i <= (no_idle || $urandom_range(99) >= 15);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    lex_item_t e;
    if (rst_ni && valid_o && ready_i) begin
      if (pending_items.size() == 0) report_mismatch("item with nothing expected");
      else begin
        e = pending_items.pop_front();
        if (item_kind_o !== e.kind || token_class_o !== e.cls ||
            value_char_o !== e.ch || start_row_o !== e.row ||
            start_column_o !== e.col || last_of_step_o !== e.last)
          report_mismatch($sformatf(
            "got k%0d c%0d v%02h r%0d c%0d l%0b exp k%0d c%0d v%02h r%0d c%0d l%0b",
            item_kind_o, token_class_o, value_char_o, start_row_o,
            start_column_o, last_of_step_o, e.kind, e.cls, e.ch, e.row, e.col,
            e.last));
      end
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LimitCycles) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  initial begin
    mismatches = 0;
    cycle_count = 0;
    sent_count = 0;
    hold_off = 1'b0;
    no_idle = 1'b0;
    quiet_done = 1'b0;
    hold_done = 1'b0;
    rst_ni = 1'b0;
    valid_i = 1'b0;
    source_byte_i = 8'h00;
    end_of_source_i = 1'b0;
    lexer_clear();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, mode switches, escapes, strays, flushes
    dir_rows = '{
      '{8'h00, 1'b0, 0}, '{8'hff, 1'b0, 2}, '{8'h00, 1'b1, 2},
      '{8'h00, 1'b1, 0},
      '{"<", 1'b0, 0}, '{"?", 1'b0, 0}, '{"%", 1'b0, 0}, '{"?", 1'b0, 0},
      '{"\\", 1'b0, 0}, '{"\"", 1'b0, 0}, '{"\\", 1'b0, 1}, '{"z", 1'b0, 0},
      '{"\\", 1'b0, -1}, '{"\"", 1'b0, -1}, '{"(", 1'b0, -1},
      '{"7", 1'b0, -1}, '{"=", 1'b0, -1}, '{"=", 1'b0, -1},
      '{"?", 1'b0, -1}, '{">", 1'b0, -1}, '{"\\", 1'b0, -1}, '{8'h00, 1'b1, -1}
    };
    foreach (dir_rows[i]) send_byte(dir_rows[i].b, dir_rows[i].eos, dir_rows[i].nexp);

    // random part, with a stretch of no idling and one long hold-off
    while (sent_count < 92) begin
      if (!quiet_done && sent_count >= 40) begin
        no_idle = 1'b1;
        quiet_done = 1'b1;
      end
      if (!hold_done && sent_count >= 65) begin
        no_idle = 1'b0;
        hold_off = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(99) < 4) send_byte(8'($urandom_range(255)), 1'b1, -1);
      else send_fragment();
    end
    // long line for row/column growth
    for (int i = 0; i < 20; i++) send_byte(8'($urandom_range(255)), 1'b0, -1);
    send_byte(8'h00, 1'b1, -1);
    valid_i <= 1'b0;

    while (pending_items.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && pending_items.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
